// ===== sv/prq_pkg.sv =====
package prq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int ID_BITS_DEF   = 16;

    typedef enum logic
    {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_type_t;

    // per-cycle command broadcast to every cell, already gated by full/empty
    typedef struct packed
    {
        logic enq;
        logic deq;
    } prq_ctl_t;

endpackage

// ===== sv/prq_if.sv =====
interface prq_req_if #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
);
    import prq_pkg::*;

    logic                 valid;
    logic                 ready;
    req_type_t            req_type;
    logic [ID_BITS-1:0]   proc_id;
    logic [PRIO_BITS-1:0] prio;

    modport source (output valid, req_type, proc_id, prio, input ready);
    modport sink   (input valid, req_type, proc_id, prio, output ready);
endinterface

interface prq_rsp_if #(
    parameter int ID_BITS  = 16,
    parameter int CNT_BITS = 5
);
    logic                valid;
    logic                ready;
    logic [ID_BITS-1:0]  out_id;
    logic                out_valid;
    logic                empty_error;
    logic                full_drop;
    logic [CNT_BITS-1:0] count;
    logic                has_entries;

    modport source (output valid, out_id, out_valid, empty_error, full_drop, count,
                    has_entries, input ready);
    modport sink   (input valid, out_id, out_valid, empty_error, full_drop, count,
                    has_entries, output ready);
endinterface

// ===== sv/prq_cell.sv =====
module prq_cell #(
    parameter int ID_BITS   = prq_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
    input  logic                 clk,
    input  prq_pkg::prq_ctl_t    ctl,
    input  logic                 occ,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic                 left_take,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [PRIO_BITS-1:0] right_prio,
    output logic                 take,
    output logic [ID_BITS-1:0]   id,
    output logic [PRIO_BITS-1:0] prio
);
    import prq_pkg::*;

    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // new entry belongs at or before this slot
    assign take = !occ || (prio_reg <= new_prio);

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        priority if (ctl.enq && take && left_take)
        begin
            id_next   = left_id;
            prio_next = left_prio;
        end
        else if (ctl.enq && take)
        begin
            id_next   = new_id;
            prio_next = new_prio;
        end
        else if (ctl.deq)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

// ===== sv/priority_ready_queue_core.sv =====
// Sorted ready queue for a priority scheduler.
// req channel: one transaction per request. req_type REQ_ENQ inserts proc_id
//   with prio in front of every stored entry of lower or equal priority;
//   REQ_DEQ removes the head (highest priority, newest among equals).
// rsp channel: exactly one transaction per request, in request order, with
//   the removed id (dequeue only), out_valid, empty_error, full_drop, the entry
//   count after the request and has_entries.
// The response is registered and is valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp is not stalled; every slot is a cell that
//   compares its priority with the incoming one and loads from its left or right
//   neighbor, so an insert or a pop updates every slot at once.
// An enqueue into a full queue and a dequeue from an empty queue leave the
//   queue unchanged and only flag the response.
// Reset clears the entry count and the response valid flag; the queue is empty.
// If rsp is stalled the response register holds and req.ready drops; a new
//   request is taken in the same cycle the pending response leaves.
module priority_ready_queue_core #(
    parameter int DEPTH     = prq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF,
    parameter int ID_BITS   = prq_pkg::ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    prq_req_if.sink   req,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    prq_ctl_t             ctl;
    logic                 req_fire;
    logic                 is_enq;
    logic                 full;
    logic                 empty;

    logic [ID_BITS-1:0]   cell_id   [DEPTH+1];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH+1];
    logic                 cell_take [DEPTH];

    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [ID_BITS-1:0]   out_id_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 empty_error_reg;
    logic                 empty_error_next;
    logic                 full_drop_reg;
    logic                 full_drop_next;
    logic [CNT_BITS-1:0]  rsp_count_reg;
    logic                 has_entries_reg;
    logic                 has_entries_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign is_enq    = (req.req_type == REQ_ENQ);
    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ctl.enq   = req_fire && is_enq && !full;
    assign ctl.deq   = req_fire && !is_enq && !empty;

    assign cell_id[DEPTH]   = '0;
    assign cell_prio[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 left_take;
        logic [ID_BITS-1:0]   left_id;
        logic [PRIO_BITS-1:0] left_prio;

        if (i == 0)
        begin : g_head
            assign left_take = 1'b0;
            assign left_id   = req.proc_id;
            assign left_prio = req.prio;
        end
        else
        begin : g_body
            assign left_take = cell_take[i-1];
            assign left_id   = cell_id[i-1];
            assign left_prio = cell_prio[i-1];
        end

        prq_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occ        (count_reg > CNT_BITS'(i)),
            .new_id     (req.proc_id),
            .new_prio   (req.prio),
            .left_take  (left_take),
            .left_id    (left_id),
            .left_prio  (left_prio),
            .right_id   (cell_id[i+1]),
            .right_prio (cell_prio[i+1]),
            .take       (cell_take[i]),
            .id         (cell_id[i]),
            .prio       (cell_prio[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.enq)
            count_next = count_reg + CNT_BITS'(1);
        else if (ctl.deq)
            count_next = count_reg - CNT_BITS'(1);
    end

    assign rsp_valid_next   = req_fire || (rsp_valid_reg && !rsp.ready);
    assign out_id_next      = ctl.deq ? cell_id[0] : '0;
    assign out_valid_next   = ctl.deq;
    assign empty_error_next = req_fire && !is_enq && empty;
    assign full_drop_next   = req_fire && is_enq && full;
    assign has_entries_next = (count_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            out_id_reg      <= out_id_next;
            out_valid_reg   <= out_valid_next;
            empty_error_reg <= empty_error_next;
            full_drop_reg   <= full_drop_next;
            rsp_count_reg   <= count_next;
            has_entries_reg <= has_entries_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_id      = out_id_reg;
    assign rsp.out_valid   = out_valid_reg;
    assign rsp.empty_error = empty_error_reg;
    assign rsp.full_drop   = full_drop_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.has_entries = has_entries_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_BITS'(2) |-> cell_prio[0] >= cell_prio[1])
        else $error("head entries out of priority order");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("enqueue did not grow the queue");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp.valid && rsp.count == count_reg)
        else $error("response count does not match queue");

    a_rsp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.out_valid && (rsp.empty_error || rsp.full_drop))
                      && (rsp.has_entries == (rsp.count != '0)))
        else $error("inconsistent response flags");

endmodule

// ===== dv/prq_checker.sv =====
`timescale 1ns / 100ps

module prq_checker (
    input  logic clk,
    input  logic rst_n,
    prq_req_if   req,
    prq_rsp_if   rsp,
    output int   errors,
    output int   pending
);
    import prq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH_DEF + 1);

    typedef struct packed
    {
        logic [ID_BITS_DEF-1:0] out_id;
        logic                   out_valid;
        logic                   empty_error;
        logic                   full_drop;
        logic [CNT_BITS-1:0]    count;
        logic                   has_entries;
    } sched_rsp_t;

    logic [ID_BITS_DEF-1:0]   slot_id   [DEPTH_DEF];
    logic [PRIO_BITS_DEF-1:0] slot_prio [DEPTH_DEF];
    int                       slot_count;
    sched_rsp_t               expected_rsp_q [$];
    int                       mismatch_cnt;

    // sorted insert / head pop, newest first among equal priorities
    function automatic sched_rsp_t apply_request(req_type_t kind,
                                                 logic [ID_BITS_DEF-1:0] id,
                                                 logic [PRIO_BITS_DEF-1:0] pr);
        sched_rsp_t r;
        int         pos;
        r = '0;
        if (kind == REQ_ENQ)
        begin
            if (slot_count >= DEPTH_DEF)
                r.full_drop = 1'b1;
            else
            begin
                pos = 0;
                while (pos < slot_count && pr < slot_prio[pos])
                    pos++;
                for (int i = slot_count; i > pos; i--)
                begin
                    slot_id[i]   = slot_id[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_id[pos]   = id;
                slot_prio[pos] = pr;
                slot_count++;
            end
        end
        else
        begin
            if (slot_count == 0)
                r.empty_error = 1'b1;
            else
            begin
                r.out_id    = slot_id[0];
                r.out_valid = 1'b1;
                for (int i = 1; i < slot_count; i++)
                begin
                    slot_id[i-1]   = slot_id[i];
                    slot_prio[i-1] = slot_prio[i];
                end
                slot_count--;
            end
        end
        r.count       = slot_count[CNT_BITS-1:0];
        r.has_entries = (slot_count > 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_rsp_t got;
        sched_rsp_t want;
        if (!rst_n)
        begin
            slot_count = 0;
            expected_rsp_q.delete();
            mismatch_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.out_id, rsp.out_valid, rsp.empty_error, rsp.full_drop,
                        rsp.count, rsp.has_entries};
                if (expected_rsp_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: response transaction with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got !== want)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: exp id=%h ov=%b ee=%b fd=%b cnt=%0d he=%b",
                                      " / got id=%h ov=%b ee=%b fd=%b cnt=%0d he=%b"},
                                     $realtime, want.out_id, want.out_valid,
                                     want.empty_error, want.full_drop, want.count,
                                     want.has_entries, got.out_id, got.out_valid,
                                     got.empty_error, got.full_drop, got.count,
                                     got.has_entries);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_rsp_q.push_back(apply_request(req.req_type, req.proc_id, req.prio));
            errors  <= mismatch_cnt;
            pending <= expected_rsp_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import prq_pkg::*;

    localparam int CNT_BITS   = $clog2(DEPTH_DEF + 1);
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n = 1'b0;
    logic idle_en;
    int   stall_left;
    int   quiet_cycles;
    int   errors;
    int   pending;

    prq_req_if #(.ID_BITS(ID_BITS_DEF), .PRIO_BITS(PRIO_BITS_DEF)) req ();
    prq_rsp_if #(.ID_BITS(ID_BITS_DEF), .CNT_BITS(CNT_BITS))       rsp ();

    priority_ready_queue_core #(
        .DEPTH     (DEPTH_DEF),
        .PRIO_BITS (PRIO_BITS_DEF),
        .ID_BITS   (ID_BITS_DEF)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    prq_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // response backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 99) < 25)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= gap_len() - 1;
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_req(input req_type_t kind, input logic [ID_BITS_DEF-1:0] id,
                            input logic [PRIO_BITS_DEF-1:0] pr);
        int gap;
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.proc_id  <= id;
        req.prio     <= pr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        gap = (idle_en && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_wait();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                       mode;
        int                       enq_pct;
        req_type_t                kind;
        logic [PRIO_BITS_DEF-1:0] pr;
        req.valid    = 1'b0;
        req.req_type = REQ_ENQ;
        req.proc_id  = '0;
        req.prio     = '0;
        idle_en      = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pop, field extremes, ordering, fill with ties, full drop
        send_req(REQ_DEQ, 16'h5A5A, 8'hA5);
        send_req(REQ_ENQ, 16'hFFFF, 8'hFF);
        send_req(REQ_ENQ, 16'h0000, 8'h00);
        send_req(REQ_DEQ, 16'h0000, 8'h00);
        send_req(REQ_DEQ, 16'hFFFF, 8'hFF);
        send_req(REQ_DEQ, 16'h0000, 8'h00);
        for (int i = 0; i < DEPTH_DEF; i++)
            send_req(REQ_ENQ, 16'h1000 + i[15:0],
                     (i < 6) ? 8'h80 : ((i < 11) ? 8'h00 : 8'hFF));
        send_req(REQ_ENQ, 16'hBEEF, 8'hFF);
        send_req(REQ_DEQ, 16'hFFFF, 8'hFF);
        send_req(REQ_DEQ, 16'h0000, 8'h00);

        for (int blk = 0; blk < 17; blk++)
        begin
            mode = blk % 4;
            idle_en <= (mode != 3);
            enq_pct = (mode == 0) ? 80 : ((mode == 1) ? 25 : 55);
            for (int n = 0; n < 50; n++)
            begin
                kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: pr = PRIO_BITS_DEF'($urandom_range(0, 3));
                    4:          pr = '1;
                    5:          pr = '0;
                    default:    pr = PRIO_BITS_DEF'($urandom);
                endcase
                send_req(kind, ID_BITS_DEF'($urandom), pr);
            end
            if (blk == 8)
                drain_wait();
        end

        drain_wait();
        repeat (5) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/prq_pkg.sv
sv/prq_if.sv
sv/prq_cell.sv
sv/priority_ready_queue_core.sv
dv/prq_checker.sv
dv/tb_top.sv
